[hw/rtl/mqtt_publish_packet_framer_assert.svh]
// assertion macros for the mqtt publish framer
// expects clk and rst_n in the scope of the use
`ifndef MQTT_PUBLISH_PACKET_FRAMER_ASSERT_SVH
`define MQTT_PUBLISH_PACKET_FRAMER_ASSERT_SVH

// checked only while out of reset
`define MQTTPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MQTTPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/mqttpf_pkg.sv]
// shared types and constants for the mqtt publish framer
// used by mqttpf_decode and mqtt_publish_packet_framer
package mqttpf_pkg;

  localparam int unsigned MAX_RES = 6;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RES);

  localparam logic [7:0]  PKT_PUBLISH  = 8'h30;
  localparam logic [7:0]  PKT_PINGREQ  = 8'hC0;
  localparam logic [15:0] MIN_CAPACITY = 16'd256;
  localparam logic [15:0] MIN_PING_CAP = 16'd2;
  localparam logic [17:0] HDR_SLACK    = 18'd7;
  localparam logic [15:0] CAP_RESET    = 16'd1024;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_PING  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ERR_CAP = 2'd1,
    ST_ERR_LEN = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  status;
    logic        last;
    logic [15:0] len;
  } ent_t;

  typedef struct packed {
    ent_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]   count;
  } job_t;

  typedef struct packed {
    logic        open;
    logic [16:0] bytes_left;
    logic [15:0] total_len;
  } pstate_t;

endpackage

[hw/rtl/mqttpf_decode.sv]
// turns one input beat plus packet state into its list of result bytes
// and the next packet state; depends on mqttpf_pkg
module mqttpf_decode (
  input  logic [1:0]         cmd,
  input  logic [15:0]        topic_len,
  input  logic [15:0]        msg_len,
  input  logic [7:0]         data_byte,
  input  logic [15:0]        cap,
  input  mqttpf_pkg::pstate_t st_i,
  output mqttpf_pkg::job_t    job_o,
  output mqttpf_pkg::pstate_t st_o
);
  import mqttpf_pkg::*;

  logic [16:0] sum;
  logic [17:0] need;
  logic        fits;
  logic [16:0] rem;
  logic [1:0]  nc;
  logic [7:0]  code0, code1, code2;
  logic [15:0] total;
  logic        empty;
  logic [16:0] bl;
  logic        fin;

  always_comb begin
    sum   = {1'b0, topic_len} + {1'b0, msg_len};
    need  = {1'b0, sum} + HDR_SLACK;
    fits  = need <= {2'b00, cap};
    rem   = sum + 17'd2;
    empty = sum == 17'd0;
    // continuation coded remaining length, at most three bytes here
    code0 = {rem[16:7] != 10'd0, rem[6:0]};
    code1 = {rem[16:14] != 3'd0, rem[13:7]};
    code2 = {5'd0, rem[16:14]};
    if (rem[16:7] == 10'd0) nc = 2'd1;
    else if (rem[16:14] == 3'd0) nc = 2'd2;
    else nc = 2'd3;
    total = 16'(sum + 17'(nc) + 17'd3);
    bl    = st_i.bytes_left - 17'(st_i.bytes_left != 17'd0);
    fin   = bl == 17'd0;

    job_o = '0;
    st_o  = st_i;
    unique case (cmd)
      CMD_START: begin
        if (!st_i.open) begin
          if (cap < MIN_CAPACITY) begin
            job_o.count  = CNT_W'(1);
            job_o.ent[0] = '{data: 8'h00, status: ST_ERR_CAP, last: 1'b1, len: 16'd0};
          end else if (!fits) begin
            job_o.count  = CNT_W'(1);
            job_o.ent[0] = '{data: 8'h00, status: ST_ERR_LEN, last: 1'b1, len: 16'd0};
          end else begin
            job_o.count = CNT_W'(nc) + CNT_W'(3);
            for (int k = 0; k < MAX_RES; k++) begin
              job_o.ent[k].len = total;
            end
            job_o.ent[0].data = PKT_PUBLISH;
            job_o.ent[1].data = code0;
            unique case (nc)
              2'd2: begin
                job_o.ent[2].data = code1;
                job_o.ent[3].data = topic_len[15:8];
                job_o.ent[4].data = topic_len[7:0];
                job_o.ent[4].last = empty;
              end
              2'd3: begin
                job_o.ent[2].data = code1;
                job_o.ent[3].data = code2;
                job_o.ent[4].data = topic_len[15:8];
                job_o.ent[5].data = topic_len[7:0];
                job_o.ent[5].last = empty;
              end
              default: begin
                job_o.ent[2].data = topic_len[15:8];
                job_o.ent[3].data = topic_len[7:0];
                job_o.ent[3].last = empty;
              end
            endcase
            if (!empty) begin
              st_o.open       = 1'b1;
              st_o.bytes_left = sum;
              st_o.total_len  = total;
            end
          end
        end
      end
      CMD_DATA: begin
        if (st_i.open) begin
          job_o.count  = CNT_W'(1);
          job_o.ent[0] = '{data: data_byte, status: ST_OK, last: fin, len: st_i.total_len};
          st_o.bytes_left = bl;
          if (fin) begin
            st_o.open      = 1'b0;
            st_o.total_len = 16'd0;
          end
        end
      end
      CMD_PING: begin
        if (!st_i.open) begin
          if (cap < MIN_PING_CAP) begin
            job_o.count  = CNT_W'(1);
            job_o.ent[0] = '{data: 8'h00, status: ST_ERR_CAP, last: 1'b1, len: 16'd0};
          end else begin
            job_o.count  = CNT_W'(2);
            job_o.ent[0] = '{data: PKT_PINGREQ, status: ST_OK, last: 1'b0, len: 16'd2};
            job_o.ent[1] = '{data: 8'h00, status: ST_OK, last: 1'b1, len: 16'd2};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/mqtt_publish_packet_framer.sv]
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_stall  | cmd, topic_len, msg_len, data_byte
// out_    | out | out_valid/out_stall| out_byte, status, last, packet_length
// cfg_    | in  | cfg_valid/cfg_ready| buffer capacity, 16 bits
//
// a data beat yields one result byte; a publish start yields 4 to 6 (one per
// header byte), a ping 2, an error 1, each holding the input while they drain;
// the output register drains one result per cycle unless out_stall holds it.
// rst_n is synchronous; reset empties the result list and output register and
// sets capacity to 1024. out_stall holds the output register and, once the
// result list is down to its last byte, the input too.
// top level of the mqtt publish framer; uses mqttpf_pkg, mqttpf_decode
// and the assertion macros in mqtt_publish_packet_framer_assert.svh
`include "mqtt_publish_packet_framer_assert.svh"

module mqtt_publish_packet_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_topic_len,
  input  logic [15:0] in_msg_len,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_status,
  output logic        out_last,
  output logic [15:0] out_packet_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import mqttpf_pkg::*;

  logic [15:0]      cap_r, cap_nxt;
  pstate_t          st_r, st_nxt, st_dec;
  job_t             job_r, job_nxt, job_dec;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  ent_t             out_r, out_nxt;
  logic             emit;
  logic             accept;

  mqttpf_decode u_decode (
    .cmd         (in_cmd),
    .topic_len   (in_topic_len),
    .msg_len     (in_msg_len),
    .data_byte   (in_data_byte),
    .cap         (cap_r),
    .st_i        (st_r),
    .job_o       (job_dec),
    .st_o        (st_dec)
  );

  assign cfg_ready = 1'b1;
  assign emit      = (cnt_r != '0) && (!out_valid_r || !out_stall);
  // take a new beat once the list is empty or its last byte leaves now
  assign in_stall  = !((cnt_r == '0) || ((cnt_r == CNT_W'(1)) && emit));
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cap_nxt       = cap_r;
    st_nxt        = st_r;
    job_nxt       = job_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (cfg_valid && cfg_ready) cap_nxt = cfg_data;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = job_r.ent[idx_r];
      cnt_nxt       = cnt_r - CNT_W'(1);
      idx_nxt       = idx_r + IDX_W'(1);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      st_nxt  = st_dec;
      job_nxt = job_dec;
      cnt_nxt = job_dec.count;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      st_r        <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_r.data;
  assign out_status        = out_r.status;
  assign out_last          = out_r.last;
  assign out_packet_length = out_r.len;

  `MQTTPF_ASSERT(a_open_has_bytes, st_r.open |-> (st_r.bytes_left != 17'd0) && (st_r.total_len != 16'd0), "open packet without pending bytes or length")
  `MQTTPF_ASSERT(a_err_shape, (out_valid_r && (out_r.status != ST_OK)) |-> (out_r.last && (out_r.len == 16'd0) && (out_r.data == 8'h00)), "malformed error result")
  `MQTTPF_ASSERT(a_list_bound, (cnt_r != '0) |-> ((32'(idx_r) + 32'(cnt_r)) <= MAX_RES), "result list index runs past its end")

endmodule
